// File: rtl/tftp_dbs_pkg.sv
// ----------------------------------------------------------------------------
// TFTP data block sender - shared definitions
// Widths, protocol codes, register indexes and the request and result
// structures used by every module of the data block sender.
// ----------------------------------------------------------------------------
package tftp_dbs_pkg;

	// Sizing
	localparam int BLOCK_BYTES = 512;
	localparam int SIZE_BITS   = 24;
	localparam int LEN_W       = $clog2(BLOCK_BYTES + 1);
	localparam int PROD_W      = 16 + $clog2(BLOCK_BYTES + 1);
	localparam int CFG_IDX_W   = 2;

	// Protocol constants
	localparam logic [15:0] TFTP_PORT = 16'd69;
	localparam logic [15:0] OP_RRQ    = 16'd1;
	localparam logic [15:0] OP_ACK    = 16'd4;

	// Requested file classes
	localparam logic [1:0] FILE_KERNEL = 2'd0;
	localparam logic [1:0] FILE_ROOTFS = 2'd1;

	// Image selection codes
	localparam logic [1:0] IMG_KERNEL = 2'd0;
	localparam logic [1:0] IMG_ROOTFS = 2'd1;
	localparam logic [1:0] IMG_PRESET = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_IGNORED  = 2'd0;
	localparam logic [1:0] ST_DATA     = 2'd1;
	localparam logic [1:0] ST_COMPLETE = 2'd2;
	localparam logic [1:0] ST_ERROR    = 2'd3;

	// Acknowledgement mismatch codes
	localparam logic [1:0] MIS_NONE   = 2'd0;
	localparam logic [1:0] MIS_OLD    = 2'd1;
	localparam logic [1:0] MIS_UNSENT = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CLIENT_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BYTES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROOTFS_BYTES = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRESET_BYTES = 2'd3;

	typedef struct packed {
		logic [15:0] src_udp;
		logic [15:0] dst_udp;
		logic [15:0] req_type;
		logic [15:0] block_number;
		logic [1:0]  file_class;
	} req_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [15:0]          reply_src_udp;
		logic [15:0]          reply_dst_udp;
		logic [15:0]          data_block;
		logic [SIZE_BITS-1:0] data_offset;
		logic [LEN_W-1:0]     data_length;
		logic [1:0]           image_select;
		logic [1:0]           ack_mismatch;
	} res_t;

	typedef struct packed {
		logic                 client_mode;
		logic [SIZE_BITS-1:0] kernel_bytes;
		logic [SIZE_BITS-1:0] rootfs_bytes;
		logic [SIZE_BITS-1:0] preset_bytes;
	} cfg_t;

endpackage

// File: rtl/tftp_dbs_cfg.sv
// ----------------------------------------------------------------------------
// TFTP data block sender - configuration registers
// Holds the mode bit and the three image sizes written through the plain
// write port, and presents them as one structure.
// ----------------------------------------------------------------------------
module tftp_dbs_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tftp_dbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tftp_dbs_pkg::SIZE_BITS-1:0]  cfg_wdata,
	output tftp_dbs_pkg::cfg_t                  cfg
);

	tftp_dbs_pkg::cfg_t cfg_q;

	// Capture a write into the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tftp_dbs_pkg::REG_CLIENT_MODE:  cfg_q.client_mode  <= cfg_wdata[0];
				tftp_dbs_pkg::REG_KERNEL_BYTES: cfg_q.kernel_bytes <= cfg_wdata;
				tftp_dbs_pkg::REG_ROOTFS_BYTES: cfg_q.rootfs_bytes <= cfg_wdata;
				tftp_dbs_pkg::REG_PRESET_BYTES: cfg_q.preset_bytes <= cfg_wdata;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/tftp_dbs_core.sv
// ----------------------------------------------------------------------------
// TFTP data block sender - transfer decision
// Holds the transfer state and decides, for one registered request, whether
// to ignore it, send the next data block, finish, or report an error. The
// state advances only when the caller commits the result.
// ----------------------------------------------------------------------------
module tftp_dbs_core (
	input  logic               clk,
	input  logic               arst_n,
	input  tftp_dbs_pkg::cfg_t cfg,
	input  tftp_dbs_pkg::req_t req,
	input  logic               commit,
	output tftp_dbs_pkg::res_t res
);

	localparam int SB = tftp_dbs_pkg::SIZE_BITS;
	localparam int LW = tftp_dbs_pkg::LEN_W;
	localparam int PW = tftp_dbs_pkg::PROD_W;

	// Transfer state
	logic [SB-1:0] image_size_q;
	logic [1:0]    cur_image_q;
	logic [SB-1:0] bytes_done_q;
	logic [15:0]   acked_block_q;
	logic [15:0]   last_sent_q;

	// Next state
	logic [SB-1:0] image_size_d;
	logic [1:0]    cur_image_d;
	logic [SB-1:0] bytes_done_d;
	logic [15:0]   acked_block_d;
	logic [15:0]   last_sent_d;

	// Decision working values
	logic          port_ok;
	logic          is_err;
	logic          do_send;
	logic [15:0]   blk;
	logic [SB-1:0] size;
	logic [SB-1:0] offset;
	logic [SB-1:0] remain;
	logic [LW-1:0] len;
	logic [15:0]   next_blk;
	logic [1:0]    mismatch;
	logic [PW-1:0] blk_end;
	logic [PW-1:0] acked_ofs;

	assign blk_end   = PW'(blk) * PW'(tftp_dbs_pkg::BLOCK_BYTES);
	assign acked_ofs = PW'(acked_block_q) * PW'(tftp_dbs_pkg::BLOCK_BYTES);

	// Decide the action and the next transfer state
	always_comb begin
		image_size_d  = image_size_q;
		cur_image_d   = cur_image_q;
		bytes_done_d  = bytes_done_q;
		acked_block_d = acked_block_q;
		last_sent_d   = last_sent_q;
		res           = '0;
		is_err        = 1'b0;
		do_send       = 1'b0;
		blk           = req.block_number;
		mismatch      = tftp_dbs_pkg::MIS_NONE;
		remain        = '0;
		len           = '0;
		next_blk      = '0;

		port_ok = cfg.client_mode ? (req.src_udp == tftp_dbs_pkg::TFTP_PORT)
		                          : (req.dst_udp == tftp_dbs_pkg::TFTP_PORT);

		// Opcode handling: a read request selects the image and restarts
		if (port_ok) begin
			if (req.req_type == tftp_dbs_pkg::OP_RRQ) begin
				if (req.file_class == tftp_dbs_pkg::FILE_KERNEL) begin
					image_size_d = cfg.kernel_bytes;
					cur_image_d  = tftp_dbs_pkg::IMG_KERNEL;
				end else if (req.file_class == tftp_dbs_pkg::FILE_ROOTFS) begin
					image_size_d = cfg.rootfs_bytes;
					cur_image_d  = tftp_dbs_pkg::IMG_ROOTFS;
				end else begin
					is_err = 1'b1;
				end
				blk          = '0;
				bytes_done_d = '0;
			end else if (req.req_type != tftp_dbs_pkg::OP_ACK) begin
				is_err = 1'b1;
			end
		end

		size   = (cur_image_d == tftp_dbs_pkg::IMG_PRESET) ? cfg.preset_bytes : image_size_d;
		offset = bytes_done_d;

		// Block sequencing: restart, resend after the last ack, advance or finish
		if (port_ok && !is_err) begin
			if (blk == '0) begin
				acked_block_d = '0;
				offset        = '0;
				do_send       = 1'b1;
			end else if (blk != last_sent_q) begin
				mismatch = (blk < last_sent_q) ? tftp_dbs_pkg::MIS_OLD
				                               : tftp_dbs_pkg::MIS_UNSENT;
				blk      = acked_block_q;
				offset   = acked_ofs[SB-1:0];
				do_send  = 1'b1;
			end else if (blk_end > PW'(size)) begin
				res.status = cfg.client_mode ? tftp_dbs_pkg::ST_COMPLETE
				                             : tftp_dbs_pkg::ST_IGNORED;
			end else begin
				acked_block_d = blk;
				do_send       = 1'b1;
			end
		end

		if (port_ok && is_err) begin
			res.status = tftp_dbs_pkg::ST_ERROR;
		end

		// Payload length and the outgoing block description
		if (do_send) begin
			remain = size - offset;
			if (offset >= size) begin
				len = '0;
			end else if (remain > SB'(tftp_dbs_pkg::BLOCK_BYTES)) begin
				len = LW'(tftp_dbs_pkg::BLOCK_BYTES);
			end else begin
				len = remain[LW-1:0];
			end
			next_blk     = blk + 16'd1;
			bytes_done_d = offset + SB'(len);
			last_sent_d  = next_blk;

			res.status        = tftp_dbs_pkg::ST_DATA;
			res.reply_src_udp = req.dst_udp;
			res.reply_dst_udp = req.src_udp;
			res.data_block    = next_blk;
			res.data_offset   = offset;
			res.data_length   = len;
			res.image_select  = cur_image_d;
			res.ack_mismatch  = mismatch;
		end else begin
			// Nothing sent: drop every state change
			image_size_d  = image_size_q;
			cur_image_d   = cur_image_q;
			bytes_done_d  = bytes_done_q;
			acked_block_d = acked_block_q;
			last_sent_d   = last_sent_q;
		end
	end

	// Advance the transfer state when the result is committed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q  <= '0;
			cur_image_q   <= tftp_dbs_pkg::IMG_PRESET;
			bytes_done_q  <= '0;
			acked_block_q <= '0;
			last_sent_q   <= '0;
		end else if (commit) begin
			image_size_q  <= image_size_d;
			cur_image_q   <= cur_image_d;
			bytes_done_q  <= bytes_done_d;
			acked_block_q <= acked_block_d;
			last_sent_q   <= last_sent_d;
		end
	end

endmodule

// File: rtl/tftp_data_block_sender.sv
// ----------------------------------------------------------------------------
// TFTP data block sender - top level
// Decides, per received TFTP header, the next data block of a lock-step
// transfer: its ports, block number, byte offset, length and image.
// ----------------------------------------------------------------------------
// Usage:
//   Requests (req_data) enter on req_valid/req_ready; one result per request
//   leaves on res_valid/res_ready (res_data). Configuration is written on
//   cfg_we/cfg_index/cfg_wdata while no request is in flight.
//   A request is held in the request register, decided combinationally from
//   it, and its result is registered in the result register. Throughput:
//   one request per cycle while the receiver takes results; the decision
//   between the request register and the result register reads and
//   updates the transfer state in the same cycle, so requests may follow
//   back to back.
//   A stalled receiver holds the result register; the request register still
//   takes one more request, after which req_ready drops until the result
//   is taken.
//   Reset clears the configuration to zero, empties both registers and puts
//   the transfer state back to block 0 on the preset image. No clearing pass.
// ----------------------------------------------------------------------------
module tftp_data_block_sender (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  tftp_dbs_pkg::req_t                  req_data,
	output logic                                res_valid,
	input  logic                                res_ready,
	output tftp_dbs_pkg::res_t                  res_data,
	input  logic                                cfg_we,
	input  logic [tftp_dbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tftp_dbs_pkg::SIZE_BITS-1:0]  cfg_wdata
);

	tftp_dbs_pkg::cfg_t cfg;
	tftp_dbs_pkg::req_t req_s1;
	tftp_dbs_pkg::res_t res_d;
	tftp_dbs_pkg::res_t res_q;
	logic               req_vld_s1;
	logic               res_vld_q;
	logic               advance;

	tftp_dbs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	tftp_dbs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req_s1),
		.commit (advance),
		.res    (res_d)
	);

	// Move the held request into the result register when it is free
	assign advance   = req_vld_s1 && (!res_vld_q || res_ready);
	assign req_ready = !req_vld_s1 || advance;

	// Request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_vld_s1 <= 1'b0;
		end else if (req_ready) begin
			req_vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req_data;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (advance) begin
			res_vld_q <= 1'b1;
		end else if (res_ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_vld_q;
	assign res_data  = res_q;

	// Checks
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld_q && !res_ready) |-> !advance)
		else $error("result overwritten while stalled");

	a_advance_needs_req: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> req_vld_s1)
		else $error("advance without a held request");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q |-> (res_q.data_length <= tftp_dbs_pkg::LEN_W'(tftp_dbs_pkg::BLOCK_BYTES)))
		else $error("data length beyond block size");

	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld_q && res_q.status != tftp_dbs_pkg::ST_DATA) |->
		(res_q.data_block == '0 && res_q.data_length == '0 && res_q.ack_mismatch == '0))
		else $error("block fields set on a non-data result");

	a_taken_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(req_vld_s1 && res_vld_q && !res_ready) |=> req_vld_s1)
		else $error("held request lost during stall");

endmodule

// File: sim/tftp_dbs_checker.sv
// ----------------------------------------------------------------------------
// TFTP data block sender - result checker
// Watches the request, result and configuration ports, keeps its own copy of
// the registers and the transfer state, works out the expected result for
// every accepted request and compares each accepted result with it.
// ----------------------------------------------------------------------------
module tftp_dbs_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	input  logic                               req_ready,
	input  tftp_dbs_pkg::req_t                 req_data,
	input  logic                               res_valid,
	input  logic                               res_ready,
	input  tftp_dbs_pkg::res_t                 res_data,
	input  logic                               cfg_we,
	input  logic [tftp_dbs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tftp_dbs_pkg::SIZE_BITS-1:0] cfg_wdata,
	output int                                 mismatches,
	output int                                 outstanding
);

	localparam int          SB        = tftp_dbs_pkg::SIZE_BITS;
	localparam int          LW        = tftp_dbs_pkg::LEN_W;
	localparam int          BB        = tftp_dbs_pkg::BLOCK_BYTES;
	localparam logic [31:0] SIZE_MASK = (32'd1 << SB) - 32'd1;

	// Register copy
	logic          client_q;
	logic [SB-1:0] kernel_q;
	logic [SB-1:0] rootfs_q;
	logic [SB-1:0] preset_q;

	// Transfer state
	logic [SB-1:0] image_bytes;
	logic [1:0]    image_sel;
	logic [SB-1:0] sent_bytes;
	logic [15:0]   acked_blk;
	logic [15:0]   sent_blk;

	tftp_dbs_pkg::res_t due_results[$];
	int                 result_no;

	function automatic string show(input tftp_dbs_pkg::res_t x);
		return $sformatf("st=%0d src=%0d dst=%0d blk=%0d off=%0d len=%0d img=%0d mis=%0d",
			x.status, x.reply_src_udp, x.reply_dst_udp, x.data_block,
			x.data_offset, x.data_length, x.image_select, x.ack_mismatch);
	endfunction

	// Decide the answer to one request and advance the transfer state
	task automatic decide_block(input tftp_dbs_pkg::req_t r, output tftp_dbs_pkg::res_t d);
		logic [15:0] blk;
		logic [31:0] size;
		logic [31:0] offset;
		logic [31:0] len;
		logic [1:0]  mis;
		d   = '0;
		mis = tftp_dbs_pkg::MIS_NONE;
		blk = r.block_number;
		// drop datagrams that fail the port filter
		if (!client_q && r.dst_udp != tftp_dbs_pkg::TFTP_PORT)
			return;
		if (client_q && r.src_udp != tftp_dbs_pkg::TFTP_PORT)
			return;
		if (r.req_type == tftp_dbs_pkg::OP_RRQ) begin
			if (r.file_class == tftp_dbs_pkg::FILE_KERNEL) begin
				image_bytes = kernel_q;
				image_sel   = tftp_dbs_pkg::IMG_KERNEL;
			end else if (r.file_class == tftp_dbs_pkg::FILE_ROOTFS) begin
				image_bytes = rootfs_q;
				image_sel   = tftp_dbs_pkg::IMG_ROOTFS;
			end else begin
				d.status = tftp_dbs_pkg::ST_ERROR;
				return;
			end
			blk        = '0;
			sent_bytes = '0;
		end else if (r.req_type != tftp_dbs_pkg::OP_ACK) begin
			d.status = tftp_dbs_pkg::ST_ERROR;
			return;
		end
		// the preset size is read live while no image has been requested
		size   = (image_sel == tftp_dbs_pkg::IMG_PRESET) ? 32'(preset_q) : 32'(image_bytes);
		offset = 32'(sent_bytes);
		if (blk == 16'd0) begin
			acked_blk = '0;
			sent_blk  = '0;
			offset    = '0;
		end else if (blk != sent_blk) begin
			// resend the block after the last good ack from its own offset
			mis    = (blk < sent_blk) ? tftp_dbs_pkg::MIS_OLD : tftp_dbs_pkg::MIS_UNSENT;
			blk    = acked_blk;
			offset = (32'(acked_blk) * 32'(BB)) & SIZE_MASK;
		end else begin
			if (32'(blk) * 32'(BB) > size) begin
				if (client_q)
					d.status = tftp_dbs_pkg::ST_COMPLETE;
				return;
			end
			acked_blk = blk;
		end
		if (offset >= size)
			len = '0;
		else if (size - offset > 32'(BB))
			len = 32'(BB);
		else
			len = size - offset;
		sent_bytes = SB'(offset + len);
		sent_blk   = blk + 16'd1;
		d.status        = tftp_dbs_pkg::ST_DATA;
		d.reply_src_udp = r.dst_udp;
		d.reply_dst_udp = r.src_udp;
		d.data_block    = sent_blk;
		d.data_offset   = SB'(offset);
		d.data_length   = LW'(len);
		d.image_select  = image_sel;
		d.ack_mismatch  = mis;
	endtask

	// Compare one result with the oldest expectation
	task automatic check_result(input tftp_dbs_pkg::res_t got);
		tftp_dbs_pkg::res_t want;
		string              bad;
		result_no++;
		if (due_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d arrived with nothing expected: %s", result_no, show(got));
			return;
		end
		want = due_results.pop_front();
		bad  = "";
		if (got.status !== want.status)               bad = {bad, " status"};
		if (got.reply_src_udp !== want.reply_src_udp) bad = {bad, " reply_src_udp"};
		if (got.reply_dst_udp !== want.reply_dst_udp) bad = {bad, " reply_dst_udp"};
		if (got.data_block !== want.data_block)       bad = {bad, " data_block"};
		if (got.data_offset !== want.data_offset)     bad = {bad, " data_offset"};
		if (got.data_length !== want.data_length)     bad = {bad, " data_length"};
		if (got.image_select !== want.image_select)   bad = {bad, " image_select"};
		if (got.ack_mismatch !== want.ack_mismatch)   bad = {bad, " ack_mismatch"};
		if (bad != "") begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("result %0d wrong in%s", result_no, bad);
				$display("  expected %s", show(want));
				$display("  actual   %s", show(got));
			end
		end
	endtask

	// Track registers, predict on each request, check on each result
	always @(posedge clk or negedge arst_n) begin : watch
		tftp_dbs_pkg::res_t want;
		if (!arst_n) begin
			client_q    = 1'b0;
			kernel_q    = '0;
			rootfs_q    = '0;
			preset_q    = '0;
			image_bytes = '0;
			image_sel   = tftp_dbs_pkg::IMG_PRESET;
			sent_bytes  = '0;
			acked_blk   = '0;
			sent_blk    = '0;
			mismatches  = 0;
			result_no   = 0;
			due_results.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tftp_dbs_pkg::REG_CLIENT_MODE:  client_q = cfg_wdata[0];
					tftp_dbs_pkg::REG_KERNEL_BYTES: kernel_q = cfg_wdata;
					tftp_dbs_pkg::REG_ROOTFS_BYTES: rootfs_q = cfg_wdata;
					tftp_dbs_pkg::REG_PRESET_BYTES: preset_q = cfg_wdata;
					default: ;
				endcase
			end
			if (res_valid && res_ready)
				check_result(res_data);
			if (req_valid && req_ready) begin
				decide_block(req_data, want);
				due_results.push_back(want);
			end
		end
		outstanding = due_results.size();
	end

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// TFTP data block sender - testbench top
// Drives datagram headers in bursts against a receiver that stalls on its own
// pattern: a directed pass over ports, opcodes, file names, mismatched acks
// and transfer ends, then random transfers with noise under several register
// settings. The checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

	localparam int              SB           = tftp_dbs_pkg::SIZE_BITS;
	localparam int              RANDOM_ITEMS = 1750;
	localparam int              PHASES       = 6;
	localparam int              IDLE_LIMIT   = 2000;
	localparam logic [15:0]     OP_ERROR     = 16'd5;
	localparam int unsigned     SIZE_MAX     = (1 << SB) - 1;

	logic                               clk;
	logic                               arst_n;
	logic                               req_valid;
	logic                               req_ready;
	tftp_dbs_pkg::req_t                 req_data;
	logic                               res_valid;
	logic                               res_ready;
	tftp_dbs_pkg::res_t                 res_data;
	logic                               cfg_we;
	logic [tftp_dbs_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [SB-1:0]                      cfg_wdata;
	int                                 mismatches;
	int                                 outstanding;

	// Stimulus view of the settings and of the running transfer
	bit          client;
	int unsigned kernel_sz;
	int unsigned rootfs_sz;
	int unsigned preset_sz;
	logic [1:0]  cur_img;
	bit          in_xfer;
	int          next_ack;
	int          last_ack;
	int          burst_left;

	tftp_data_block_sender uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	tftp_dbs_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req_data    (req_data),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res_data    (res_data),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Stall the result side: changing modes plus a long hold-off now and then
	initial begin : result_stalls
		int cycle;
		int hold_left;
		int mode_left;
		int ready_pct;
		cycle     = 0;
		hold_left = 0;
		mode_left = 0;
		ready_pct = 100;
		res_ready <= 1'b0;
		forever begin
			@(posedge clk);
			cycle++;
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else if (cycle % 700 == 350) begin
				hold_left = 60;
				res_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					case ($urandom_range(0, 3))
						0: ready_pct = 100;
						1: ready_pct = 75;
						2: ready_pct = 40;
						default: ready_pct = 10;
					endcase
					mode_left = $urandom_range(32, 256);
				end
				mode_left--;
				res_ready <= ($urandom_range(1, 100) <= ready_pct);
			end
		end
	end

	// End the run when nothing moves for too long
	initial begin : watchdog
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((req_valid && req_ready) || (res_valid && res_ready))
				idle = 0;
			else
				idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("** tftp_data_block_sender: FAILED **");
				$finish;
			end
		end
	end

	function automatic tftp_dbs_pkg::req_t mk(input logic [15:0] src, input logic [15:0] dst,
			input logic [15:0] op, input logic [15:0] blk, input logic [1:0] fc);
		tftp_dbs_pkg::req_t r;
		r.src_udp      = src;
		r.dst_udp      = dst;
		r.req_type     = op;
		r.block_number = blk;
		r.file_class   = fc;
		return r;
	endfunction

	function automatic int unsigned pick_size();
		if ($urandom_range(0, 3) == 0)
			return 512 * $urandom_range(0, 8);
		return $urandom_range(0, 4600);
	endfunction

	function automatic int unsigned image_sz(input logic [1:0] img);
		case (img)
			tftp_dbs_pkg::IMG_KERNEL: return kernel_sz;
			tftp_dbs_pkg::IMG_ROOTFS: return rootfs_sz;
			default:                  return preset_sz;
		endcase
	endfunction

	// Offer one request, with a random gap at the start of each burst
	task automatic offer(input tftp_dbs_pkg::req_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_data  <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
	endtask

	// Hold requests back until every result has been taken
	task automatic drain();
		req_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	// Write all four registers on consecutive edges; only while idle
	task automatic load_config(input bit m, input int unsigned k, input int unsigned rf,
			input int unsigned p);
		client    = m;
		kernel_sz = k;
		rootfs_sz = rf;
		preset_sz = p;
		cfg_we    <= 1'b1;
		cfg_index <= tftp_dbs_pkg::REG_CLIENT_MODE;
		cfg_wdata <= (SB'($urandom) & ~SB'(1)) | SB'(m);
		@(posedge clk);
		cfg_index <= tftp_dbs_pkg::REG_KERNEL_BYTES;
		cfg_wdata <= SB'(k);
		@(posedge clk);
		cfg_index <= tftp_dbs_pkg::REG_ROOTFS_BYTES;
		cfg_wdata <= SB'(rf);
		@(posedge clk);
		cfg_index <= tftp_dbs_pkg::REG_PRESET_BYTES;
		cfg_wdata <= SB'(p);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Fill in ports that pass the filter of the current mode
	task automatic good_ports(inout tftp_dbs_pkg::req_t r);
		if (client) begin
			r.src_udp = tftp_dbs_pkg::TFTP_PORT;
			r.dst_udp = 16'($urandom);
		end else begin
			r.src_udp = 16'($urandom);
			r.dst_udp = tftp_dbs_pkg::TFTP_PORT;
		end
	endtask

	// Start a transfer and note how many acks it takes to finish
	task automatic start_xfer(inout tftp_dbs_pkg::req_t r);
		if ($urandom_range(0, 5) == 0) begin
			r.req_type     = tftp_dbs_pkg::OP_ACK;
			r.block_number = '0;
		end else begin
			r.req_type     = tftp_dbs_pkg::OP_RRQ;
			r.block_number = 16'($urandom);
			r.file_class   = ($urandom_range(0, 1) == 0) ? tftp_dbs_pkg::FILE_KERNEL
			                                             : tftp_dbs_pkg::FILE_ROOTFS;
			cur_img        = (r.file_class == tftp_dbs_pkg::FILE_KERNEL)
			                 ? tftp_dbs_pkg::IMG_KERNEL : tftp_dbs_pkg::IMG_ROOTFS;
		end
		in_xfer  = 1'b1;
		next_ack = 1;
		last_ack = image_sz(cur_img) / tftp_dbs_pkg::BLOCK_BYTES + 1;
	endtask

	// Next step of a lock-step transfer
	task automatic well_formed(output tftp_dbs_pkg::req_t r);
		r = '0;
		r.file_class = 2'($urandom);
		good_ports(r);
		if (!in_xfer || next_ack > 12 || $urandom_range(0, 49) == 0) begin
			start_xfer(r);
		end else begin
			r.req_type     = tftp_dbs_pkg::OP_ACK;
			r.block_number = 16'(next_ack);
			if (next_ack == last_ack)
				in_xfer = 1'b0;
			next_ack++;
		end
	endtask

	// Something off the normal path
	task automatic noise(output tftp_dbs_pkg::req_t r);
		r = '0;
		r.file_class = 2'($urandom);
		good_ports(r);
		r.req_type     = tftp_dbs_pkg::OP_ACK;
		r.block_number = 16'($urandom);
		case ($urandom_range(0, 7))
			0: begin
				r.src_udp  = 16'($urandom);
				r.dst_udp  = 16'($urandom);
				r.req_type = 16'($urandom);
			end
			1: begin
				if (client)
					r.src_udp = tftp_dbs_pkg::TFTP_PORT ^ (16'd1 << $urandom_range(0, 15));
				else
					r.dst_udp = tftp_dbs_pkg::TFTP_PORT ^ (16'd1 << $urandom_range(0, 15));
			end
			2: r.req_type = OP_ERROR;
			3: begin
				r.req_type = 16'($urandom);
				if (r.req_type == tftp_dbs_pkg::OP_RRQ || r.req_type == tftp_dbs_pkg::OP_ACK)
					r.req_type = r.req_type ^ 16'h8000;
			end
			4: begin
				r.req_type   = tftp_dbs_pkg::OP_RRQ;
				r.file_class = 2'($urandom_range(2, 3));
			end
			5: ;
			6: begin
				if (next_ack > 1)
					r.block_number = 16'($urandom_range(1, next_ack - 1));
			end
			default: start_xfer(r);
		endcase
	endtask

	initial begin : stimulus
		tftp_dbs_pkg::req_t r;
		int                 phase;
		int                 i;
		arst_n     <= 1'b0;
		req_valid  <= 1'b0;
		req_data   <= '0;
		cfg_we     <= 1'b0;
		cfg_index  <= tftp_dbs_pkg::REG_CLIENT_MODE;
		cfg_wdata  <= '0;
		client     = 1'b0;
		kernel_sz  = 0;
		rootfs_sz  = 0;
		preset_sz  = 0;
		cur_img    = tftp_dbs_pkg::IMG_PRESET;
		in_xfer    = 1'b0;
		next_ack   = 1;
		last_ack   = 1;
		burst_left = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Client mode on the preset image, largest preset size
		load_config(1'b1, 0, 700, SIZE_MAX);
		offer(mk(tftp_dbs_pkg::TFTP_PORT, 16'h0000, tftp_dbs_pkg::OP_ACK, 16'd0,
			tftp_dbs_pkg::FILE_KERNEL));
		offer(mk(tftp_dbs_pkg::TFTP_PORT, 16'hFFFF, tftp_dbs_pkg::OP_ACK, 16'd1,
			tftp_dbs_pkg::FILE_KERNEL));
		offer(mk(16'd70, 16'd1234, tftp_dbs_pkg::OP_ACK, 16'd2, tftp_dbs_pkg::FILE_KERNEL));
		offer(mk(tftp_dbs_pkg::TFTP_PORT, 16'd1234, 16'd0, 16'd2, tftp_dbs_pkg::FILE_KERNEL));
		offer(mk(tftp_dbs_pkg::TFTP_PORT, 16'd1234, OP_ERROR, 16'd3,
			tftp_dbs_pkg::FILE_KERNEL));
		drain();

		// Shrink the preset under a running transfer, then an empty kernel
		load_config(1'b1, 0, 700, 300);
		offer(mk(tftp_dbs_pkg::TFTP_PORT, 16'd1234, tftp_dbs_pkg::OP_ACK, 16'd2,
			tftp_dbs_pkg::FILE_KERNEL));
		offer(mk(tftp_dbs_pkg::TFTP_PORT, 16'd1234, tftp_dbs_pkg::OP_RRQ, 16'd9,
			tftp_dbs_pkg::FILE_KERNEL));
		offer(mk(tftp_dbs_pkg::TFTP_PORT, 16'd1234, tftp_dbs_pkg::OP_ACK, 16'd1,
			tftp_dbs_pkg::FILE_KERNEL));
		offer(mk(tftp_dbs_pkg::TFTP_PORT, 16'd1234, tftp_dbs_pkg::OP_RRQ, 16'd0, 2'd3));
		offer(mk(tftp_dbs_pkg::TFTP_PORT, 16'd1234, tftp_dbs_pkg::OP_RRQ, 16'd0, 2'd2));
		drain();

		// Server mode: mismatched acks, end of image, restart
		load_config(1'b0, 1000, 512, 0);
		offer(mk(tftp_dbs_pkg::TFTP_PORT, 16'd68, tftp_dbs_pkg::OP_ACK, 16'd0,
			tftp_dbs_pkg::FILE_KERNEL));
		offer(mk(16'hFFFF, tftp_dbs_pkg::TFTP_PORT, tftp_dbs_pkg::OP_RRQ, 16'hFFFF,
			tftp_dbs_pkg::FILE_KERNEL));
		offer(mk(16'hFFFF, tftp_dbs_pkg::TFTP_PORT, tftp_dbs_pkg::OP_ACK, 16'd1,
			tftp_dbs_pkg::FILE_KERNEL));
		offer(mk(16'hFFFF, tftp_dbs_pkg::TFTP_PORT, tftp_dbs_pkg::OP_ACK, 16'hFFFF,
			tftp_dbs_pkg::FILE_KERNEL));
		offer(mk(16'hFFFF, tftp_dbs_pkg::TFTP_PORT, tftp_dbs_pkg::OP_ACK, 16'd1,
			tftp_dbs_pkg::FILE_KERNEL));
		offer(mk(16'hFFFF, tftp_dbs_pkg::TFTP_PORT, tftp_dbs_pkg::OP_ACK, 16'd2,
			tftp_dbs_pkg::FILE_KERNEL));
		offer(mk(16'd0, tftp_dbs_pkg::TFTP_PORT, tftp_dbs_pkg::OP_RRQ, 16'd0,
			tftp_dbs_pkg::FILE_ROOTFS));
		offer(mk(16'd0, tftp_dbs_pkg::TFTP_PORT, tftp_dbs_pkg::OP_ACK, 16'd1,
			tftp_dbs_pkg::FILE_ROOTFS));
		offer(mk(16'd0, tftp_dbs_pkg::TFTP_PORT, tftp_dbs_pkg::OP_ACK, 16'd2,
			tftp_dbs_pkg::FILE_ROOTFS));
		offer(mk(16'd0, tftp_dbs_pkg::TFTP_PORT, tftp_dbs_pkg::OP_ACK, 16'd0,
			tftp_dbs_pkg::FILE_ROOTFS));
		offer(mk(16'd0, tftp_dbs_pkg::TFTP_PORT, 16'hFFFF, 16'd0, tftp_dbs_pkg::FILE_ROOTFS));
		drain();
		cur_img = tftp_dbs_pkg::IMG_ROOTFS;

		// Random transfers with noise under changing settings
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: load_config(1'b0, 0, SIZE_MAX, pick_size());
				1: load_config(1'b1, pick_size(), pick_size(), 0);
				3: load_config(1'b1, SIZE_MAX, pick_size(), SIZE_MAX);
				default: load_config(phase % 2 == 1, pick_size(), pick_size(), pick_size());
			endcase
			in_xfer = 1'b0;
			for (i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
				if ($urandom_range(0, 4) == 0)
					noise(r);
				else
					well_formed(r);
				offer(r);
				if ($urandom_range(0, 149) == 0)
					drain();
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("** tftp_data_block_sender: PASSED **");
		else
			$display("** tftp_data_block_sender: FAILED **");
		$finish;
	end

endmodule

// File: tftp_data_block_sender.f
rtl/tftp_dbs_pkg.sv
rtl/tftp_dbs_cfg.sv
rtl/tftp_dbs_core.sv
rtl/tftp_data_block_sender.sv
sim/tftp_dbs_checker.sv
sim/testbench.sv
